// ===== hw/rtl/swe_pkg.sv =====
// Package for the sliding window extreme block: field widths, register
// indexes and the structs passed along the cell chain. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package swe_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int WS_W           = 7;
  localparam int WINDOW_MAX_DEF = 64;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIND_MINIMUM = 1'b1;

  localparam logic [WS_W-1:0] WS_RESET = 7'd3;

  // candidate held by one cell
  typedef struct packed {
    logic                       valid;
    logic signed [SAMPLE_W-1:0] value;
  } swe_slot_t;

  // carries running from newest cell to oldest
  typedef struct packed {
    logic                       pop;
    logic signed [SAMPLE_W-1:0] front;
  } swe_link_t;

endpackage

`default_nettype wire

// ===== hw/rtl/swe_cell.sv =====
// One cell of the candidate chain: holds the candidate of a fixed age,
// decides expiry and back-pop, shifts toward older cells. Uses swe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module swe_cell #(
  parameter int IDX = 0,
  parameter int KW  = 7
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               shift_i,
  input  logic                               clear_i,
  input  logic                               find_min_i,
  input  logic [KW-1:0]                      win_i,
  input  logic signed [swe_pkg::SAMPLE_W-1:0] sample_i,
  input  swe_pkg::swe_slot_t                 slot_i,
  output swe_pkg::swe_slot_t                 slot_o,
  input  swe_pkg::swe_link_t                 link_i,
  output swe_pkg::swe_link_t                 link_o
);
  import swe_pkg::*;

  logic                       valid_q;
  logic signed [SAMPLE_W-1:0] val_q;
  logic                       live;
  logic                       dom;
  logic                       popd;

  // age after this transaction is IDX+1
  assign live = valid_q && !clear_i && (KW'(IDX + 1) < win_i);
  assign dom  = find_min_i ? (val_q >= sample_i) : (val_q <= sample_i);
  assign popd = link_i.pop && (!live || dom);

  assign slot_o.valid = live && !popd;
  assign slot_o.value = val_q;
  assign link_o.pop   = popd;
  assign link_o.front = valid_q ? val_q : link_i.front;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= slot_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      val_q <= slot_i.value;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sliding_window_extreme.sv =====
// Timing: an accepted sample updates the cell chain and sets a pending result;
// that result is registered onto m_axis once the result side is free.
// Throughput: one sample per cycle while the result side keeps up; a chain of
// WINDOW_MAX cells, cell i holding the surviving candidate of age i, updates
// once per accepted sample and the front is registered when the result is sent.
// Reset: window_size 3, max mode, chain empty, no pending result.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_extreme #(
  parameter int WINDOW_MAX = swe_pkg::WINDOW_MAX_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // config write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [swe_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [swe_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // sample stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [15:0]                        s_axis_tdata,  // [15:0] sample
  input  logic                               s_axis_tuser,  // [0] first_of_sequence
  input  logic                               s_axis_tlast,  // last_of_sequence
  // result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [15:0]                        m_axis_tdata,  // [15:0] window_extreme
  output logic                               m_axis_tlast   // sequence_end
);
  import swe_pkg::*;

  localparam int CW = $clog2(WINDOW_MAX + 1);
  localparam int KW = (CW > WS_W) ? CW : WS_W;

  logic [WS_W-1:0]            ws_q;
  logic                       min_q;
  logic [KW-1:0]              ws_ext;
  logic [KW-1:0]              k_eff;

  logic [KW-1:0]              cnt_q, cnt_d, cnt_base;
  logic                       filled_q, filled_d;
  logic                       pend_q, pend_d;
  logic                       pend_last_q;
  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] out_data_q;
  logic                       out_last_q;

  logic                       accept;
  logic                       first;
  logic                       out_free;
  logic                       pend_done;
  logic signed [SAMPLE_W-1:0] sample;

  swe_slot_t                  slot [WINDOW_MAX+1];
  swe_link_t                  link [WINDOW_MAX+1];

  // config
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q  <= WS_RESET;
      min_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_WINDOW_SIZE:  ws_q  <= cfg_data_i[WS_W-1:0];
        CFG_FIND_MINIMUM: min_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign ws_ext = KW'(ws_q);

  always_comb begin
    if (ws_q == '0) begin
      k_eff = KW'(1);
    end else if (ws_ext > KW'(WINDOW_MAX)) begin
      k_eff = KW'(WINDOW_MAX);
    end else begin
      k_eff = ws_ext;
    end
  end

  // handshake
  assign out_free      = !out_valid_q || m_axis_tready;
  assign pend_done     = pend_q && out_free;
  assign s_axis_tready = !pend_q || out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign first         = s_axis_tuser;
  assign sample        = s_axis_tdata;

  // fill tracking
  always_comb begin
    cnt_base = first ? '0 : cnt_q;
    filled_d = (filled_q && !first) ||
               (({1'b0, cnt_base} + (KW+1)'(1)) >= {1'b0, k_eff});
    cnt_d    = (cnt_base == KW'(WINDOW_MAX)) ? cnt_base : cnt_base + KW'(1);
  end

  always_comb begin
    pend_d = pend_q;
    if (accept) begin
      pend_d = filled_d;
    end else if (pend_done) begin
      pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      filled_q    <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        cnt_q    <= cnt_d;
        filled_q <= filled_d;
      end
      pend_q <= pend_d;
      if (pend_done) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_last_q <= s_axis_tlast;
    end
    if (pend_done) begin
      out_data_q <= link[WINDOW_MAX].front;
      out_last_q <= pend_last_q;
    end
  end

  // cell chain, newest at cell 0
  assign slot[0].valid = 1'b1;
  assign slot[0].value = sample;
  assign link[0].pop   = 1'b1;
  assign link[0].front = '0;

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    swe_cell #(
      .IDX (i),
      .KW  (KW)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_i    (accept),
      .clear_i    (first),
      .find_min_i (min_q),
      .win_i      (k_eff),
      .sample_i   (sample),
      .slot_i     (slot[i]),
      .slot_o     (slot[i+1]),
      .link_i     (link[i]),
      .link_o     (link[i+1])
    );
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire
